### src/rrpq_pkg.sv
// Shared types and codes for the round-robin process queue.
// No dependencies; imported by the front, back and top-level modules.
package rrpq_pkg;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_REM  = 2'd1;
    localparam logic [1:0] OP_NEXT = 2'd2;

    localparam int OP_BITS      = 2;
    localparam int OUT_PID_BITS = 16;
    localparam int QUANT_BITS   = 8;
    localparam logic [QUANT_BITS-1:0] QUANT_RESET = 8'd4;

    typedef enum logic [1:0] {
        K_ADD,
        K_REM,
        K_NEXT,
        K_BAD
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_cmd_ctl;

    typedef struct packed {
        logic                    ok;
        logic [OUT_PID_BITS-1:0] served_pid;
        logic                    served_valid;
        logic [QUANT_BITS-1:0]   quantum;
        logic                    not_empty;
    } t_result;

endpackage

### src/rrpq_front.sv
// Front end: takes items, decodes the operation, masks the ID and holds
// them in a two-entry command queue. Depends on rrpq_pkg.
module rrpq_front #(
    parameter int PID_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rrpq_pkg::OP_BITS-1:0]        i_op,
    input  logic [rrpq_pkg::OUT_PID_BITS-1:0]   i_pid,
    output rrpq_pkg::t_cmd_ctl                  o_cmd,
    output logic [PID_BITS-1:0]                 o_pid,
    input  logic                                i_pop
);
    import rrpq_pkg::*;

    localparam int QDEPTH = 2;

    t_kind               r_kind [QDEPTH];
    logic [PID_BITS-1:0] r_pid  [QDEPTH];
    logic                r_wr_ptr, n_wr_ptr;
    logic                r_rd_ptr, n_rd_ptr;
    logic [1:0]          r_fill,   n_fill;
    t_kind               dec_kind;
    logic                push, pop;

    always_comb begin
        unique case (i_op)
            OP_ADD:  dec_kind = K_ADD;
            OP_REM:  dec_kind = K_REM;
            OP_NEXT: dec_kind = K_NEXT;
            default: dec_kind = K_BAD;
        endcase
    end

    assign o_ready = (r_fill != 2'(QDEPTH));
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_fill != 2'd0);

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_kind[r_wr_ptr] <= dec_kind;
            r_pid[r_wr_ptr]  <= PID_BITS'(i_pid);
        end
    end

    assign o_cmd.valid = (r_fill != 2'd0);
    assign o_cmd.kind  = r_kind[r_rd_ptr];
    assign o_pid       = r_pid[r_rd_ptr];

endmodule

### src/rrpq_back.sv
// Back end: ring storage, count and cursor, the operation sequencer and
// the result register. Depends on rrpq_pkg.
module rrpq_back #(
    parameter int MAX_PROCS = 16,
    parameter int PID_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rrpq_pkg::t_cmd_ctl                i_cmd,
    input  logic [PID_BITS-1:0]               i_pid,
    output logic                              o_pop,
    input  logic                              i_cfg_wr_en,
    input  logic [rrpq_pkg::QUANT_BITS-1:0]   i_cfg_wr_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output rrpq_pkg::t_result                 o_res
);
    import rrpq_pkg::*;

    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_NXT_RD = 3'd1;
    localparam logic [2:0] S_RM_RD  = 3'd2;
    localparam logic [2:0] S_RM_CMP = 3'd3;
    localparam logic [2:0] S_SH_RD  = 3'd4;
    localparam logic [2:0] S_SH_WR  = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [PID_BITS-1:0] mem [MAX_PROCS];
    logic [PID_BITS-1:0] r_rdata;

    logic [2:0]            r_state,  n_state;
    logic [CW-1:0]         r_count,  n_count;
    logic [IW-1:0]         r_cursor, n_cursor;
    logic [CW-1:0]         r_idx,    n_idx;
    logic [CW-1:0]         r_at,     n_at;
    logic [PID_BITS-1:0]   r_id,     n_id;
    t_result               r_res,    n_res;
    t_result               r_out,    n_out;
    logic                  r_valid,  n_valid;
    logic [QUANT_BITS-1:0] r_quantum;

    logic                rd_en, we;
    logic [IW-1:0]       rd_addr, wr_addr;
    logic [PID_BITS-1:0] wr_data;
    logic [CW-1:0]       idx_inc, cur_inc, cnt_dec, cur_adj;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign idx_inc = r_idx + CW'(1);
    assign cur_inc = CW'(r_cursor) + CW'(1);
    assign cnt_dec = r_count - CW'(1);

    always_comb begin
        cur_adj = CW'(r_cursor);
        if (cur_adj > r_at) begin
            cur_adj = cur_adj - CW'(1);
        end
        if (cur_adj >= cnt_dec) begin
            cur_adj = '0;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_idx    = r_idx;
        n_at     = r_at;
        n_id     = r_id;
        n_res    = r_res;
        n_out    = r_out;
        n_valid  = r_valid && !i_ready;
        o_pop    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = r_cursor;
        we       = 1'b0;
        wr_addr  = r_count[IW-1:0];
        wr_data  = i_pid;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    o_pop           = 1'b1;
                    n_res           = '0;
                    n_res.not_empty = (r_count != '0);
                    unique case (i_cmd.kind)
                        K_ADD: begin
                            if (r_count != CW'(MAX_PROCS)) begin
                                we              = 1'b1;
                                n_count         = r_count + CW'(1);
                                n_res.ok        = 1'b1;
                                n_res.not_empty = 1'b1;
                                if (r_count == '0) begin
                                    n_cursor = '0;
                                end
                            end
                            n_state = S_EMIT;
                        end
                        K_NEXT: begin
                            if (r_count != '0) begin
                                rd_en   = 1'b1;
                                n_state = S_NXT_RD;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        K_REM: begin
                            n_id    = i_pid;
                            n_idx   = '0;
                            n_state = S_RM_RD;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_NXT_RD: begin
                n_res.ok           = 1'b1;
                n_res.served_pid   = OUT_PID_BITS'(r_rdata);
                n_res.served_valid = 1'b1;
                n_res.quantum      = r_quantum;
                n_res.not_empty    = 1'b1;
                n_cursor           = (cur_inc >= r_count) ? '0 : cur_inc[IW-1:0];
                n_state            = S_EMIT;
            end
            S_RM_RD: begin
                if (r_idx < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[IW-1:0];
                    n_state = S_RM_CMP;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_RM_CMP: begin
                if (r_rdata == r_id) begin
                    n_at    = r_idx;
                    n_state = S_SH_RD;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_RM_RD;
                end
            end
            S_SH_RD: begin
                if (idx_inc < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = idx_inc[IW-1:0];
                    n_state = S_SH_WR;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SH_WR: begin
                we      = 1'b1;
                wr_addr = r_idx[IW-1:0];
                wr_data = r_rdata;
                n_idx   = idx_inc;
                n_state = S_SH_RD;
            end
            S_FIN: begin
                n_count         = cnt_dec;
                n_cursor        = (cnt_dec == '0) ? '0 : cur_adj[IW-1:0];
                n_res.ok        = 1'b1;
                n_res.not_empty = (cnt_dec != '0);
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (!r_valid || i_ready) begin
                    n_out   = r_res;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cursor  <= '0;
            r_valid   <= 1'b0;
            r_quantum <= QUANT_RESET;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_valid  <= n_valid;
            if (i_cfg_wr_en) begin
                r_quantum <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_at  <= n_at;
        r_id  <= n_id;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_res   = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PROCS))
        else $error("ring count above capacity");

    a_cursor_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_cursor == '0))
        else $error("cursor not at head on empty ring");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (CW'(r_cursor) < r_count))
        else $error("cursor beyond tail");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + CW'(1)) || (r_count == $past(r_count) - CW'(1))))
        else $error("ring count jumped");

endmodule

### src/round_robin_process_queue_unit.sv
// Round-robin process queue: ordered ring of process IDs with a serve cursor.
// Add appends at the tail, remove deletes the first match from the head and
// compacts the ring, next serves the ID at the cursor with the programmed
// quantum and advances the cursor. One result item per input item. Input
// items enter a two-entry command queue and are executed one at a time from
// a single-port ring memory with registered read. Add and undefined ops go
// straight from idle to the result state; next first reads the entry at
// the cursor; remove spends a read and a compare per entry in its search and
// then, on a match, one read and one write per entry behind the match for
// the shift, before the count and cursor are updated. When the ID is absent
// the search ends without a shift and the result reports not ok.
// A result waits in an output register while the next command is already
// queued.
// Depends on rrpq_pkg, rrpq_front and rrpq_back.
module round_robin_process_queue_unit #(
    parameter int MAX_PROCS = 16,
    parameter int PID_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // op [1:0], pid [17:2], zero pad [23:18]
    input  logic [23:0]                       i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // ok [0], served_pid [16:1], served_valid [17], quantum [25:18],
    // not_empty [26], zero pad [31:27]
    output logic [31:0]                       o_m_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [rrpq_pkg::QUANT_BITS-1:0]   i_cfg_wr_data
);
    import rrpq_pkg::*;

    t_cmd_ctl            cmd;
    logic [PID_BITS-1:0] cmd_pid;
    logic                pop;
    t_result             res;

    rrpq_front #(
        .PID_BITS (PID_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_op    (i_s_tdata[1:0]),
        .i_pid   (i_s_tdata[17:2]),
        .o_cmd   (cmd),
        .o_pid   (cmd_pid),
        .i_pop   (pop)
    );

    rrpq_back #(
        .MAX_PROCS (MAX_PROCS),
        .PID_BITS  (PID_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_pid         (cmd_pid),
        .o_pop         (pop),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_res         (res)
    );

    assign o_m_tdata = {5'd0, res.not_empty, res.quantum, res.served_valid,
                        res.served_pid, res.ok};

endmodule
